// File: hw/rtl/fsrq_pkg.sv
package fsrq_pkg;

    localparam int QUEUE_DEPTH  = 32;
    localparam int TASK_ID_BITS = 8;
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W        = $clog2(QUEUE_DEPTH);

    // run_time * 1024 is a left shift by ten
    localparam int SCALE_SHIFT  = 10;
    localparam int RUNTIME_W    = 32;
    localparam int DIVIDEND_W   = RUNTIME_W + SCALE_SHIFT;
    localparam int WEIGHT_W     = 17;
    localparam int DIV_CNT_W    = $clog2(DIVIDEND_W);
    localparam int NICE_W       = 6;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [RUNTIME_W-1:0]    runtime;
        logic [TASK_ID_BITS-1:0] task_id;
        logic [NICE_W-1:0]       nice;
    } entry_t;

    typedef struct packed {
        logic                 insert;
        logic                 shift_out;
        logic [RUNTIME_W-1:0] key;
        entry_t               new_entry;
    } cell_ctrl_t;

    // nice table; indices of 39 and above take the lightest weight
    function automatic logic [WEIGHT_W-1:0] weight_of(input logic [NICE_W-1:0] level);
        logic [WEIGHT_W-1:0] w;
        begin
            case (level)
                6'd0:    w = 17'd88761;
                6'd1:    w = 17'd71755;
                6'd2:    w = 17'd56483;
                6'd3:    w = 17'd46273;
                6'd4:    w = 17'd36291;
                6'd5:    w = 17'd29154;
                6'd6:    w = 17'd23254;
                6'd7:    w = 17'd18705;
                6'd8:    w = 17'd14949;
                6'd9:    w = 17'd11916;
                6'd10:   w = 17'd9548;
                6'd11:   w = 17'd7620;
                6'd12:   w = 17'd6100;
                6'd13:   w = 17'd4904;
                6'd14:   w = 17'd3906;
                6'd15:   w = 17'd3121;
                6'd16:   w = 17'd2501;
                6'd17:   w = 17'd1991;
                6'd18:   w = 17'd1586;
                6'd19:   w = 17'd1277;
                6'd20:   w = 17'd1024;
                6'd21:   w = 17'd820;
                6'd22:   w = 17'd655;
                6'd23:   w = 17'd526;
                6'd24:   w = 17'd423;
                6'd25:   w = 17'd335;
                6'd26:   w = 17'd272;
                6'd27:   w = 17'd215;
                6'd28:   w = 17'd172;
                6'd29:   w = 17'd137;
                6'd30:   w = 17'd110;
                6'd31:   w = 17'd87;
                6'd32:   w = 17'd70;
                6'd33:   w = 17'd56;
                6'd34:   w = 17'd45;
                6'd35:   w = 17'd36;
                6'd36:   w = 17'd29;
                6'd37:   w = 17'd23;
                6'd38:   w = 17'd18;
                default: w = 17'd15;
            endcase
            return w;
        end
    endfunction

endpackage

// File: hw/rtl/fsrq_divider.sv
module fsrq_divider
    import fsrq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [WEIGHT_W-1:0]   divisor,
    output logic                  done,
    output logic [RUNTIME_W-1:0]  quotient
);

    // restoring division, one quotient bit per cycle
    logic                  run_reg,  run_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [DIVIDEND_W-1:0] dq_reg,   dq_next;
    logic [WEIGHT_W-1:0]   rem_reg,  rem_next;
    logic [WEIGHT_W-1:0]   dvs_reg,  dvs_next;
    logic [WEIGHT_W:0]     trial;
    logic                  fits;

    assign trial = {rem_reg, dq_reg[DIVIDEND_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (load)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            dq_next  = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = fits ? WEIGHT_W'(trial - {1'b0, dvs_reg}) : trial[WEIGHT_W-1:0];
            dq_next  = {dq_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg[RUNTIME_W-1:0];

endmodule

// File: hw/rtl/fsrq_cell.sv
module fsrq_cell
    import fsrq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  logic       gt_prev,
    input  entry_t     prev_entry,
    input  entry_t     next_entry,
    output logic       gt,
    output entry_t     entry
);

    entry_t entry_reg, entry_next;

    // sorted chain: gt is low up to the insert point, high beyond it among occupied cells
    assign gt = occupied && (entry_reg.runtime > ctrl.key);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert)
        begin
            if (gt_prev)
                entry_next = prev_entry;
            else if (gt || !occupied)
                entry_next = ctrl.new_entry;
        end
        else if (ctrl.shift_out)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: hw/rtl/fair_share_run_queue_core.sv
// Fair-share run queue: tasks kept sorted by virtual runtime in a chain of cells.
// Command channel: a transaction is taken at a rising edge with start high and
// busy low. action selects enqueue (charge run_time*1024/weight to the runtime,
// then insert after equal keys) or dequeue (pop the least runtime).
// Result channel: done is high for exactly one cycle with status, out_task_id,
// out_runtime, out_nice_index and entry_count valid; the receiver cannot stall,
// so the result must be taken in that cycle.
// Latency: a dequeue, a full-queue enqueue or an empty-queue dequeue shows its
// result in the cycle after the command, and busy never rises, so such commands
// may follow every cycle. An accepted enqueue runs the 42-step bit-serial
// divider (one quotient bit a cycle) and then the insertion state; busy stays
// high until done rises, and no new command is taken while busy.
// Reset clears the count and all control; cell contents need no reset since a
// cell past the count is never read.
module fair_share_run_queue_core
    import fsrq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [7:0]  task_id,
    input  logic [31:0] virtual_runtime,
    input  logic [5:0]  nice_index,
    input  logic [31:0] run_time,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  out_task_id,
    output logic [31:0] out_runtime,
    output logic [5:0]  out_nice_index,
    output logic [5:0]  entry_count
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_INS  = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [RUNTIME_W-1:0]    base_reg;
    logic [RUNTIME_W-1:0]    key_reg;
    logic [TASK_ID_BITS-1:0] task_reg;
    logic [NICE_W-1:0]       nice_reg;

    logic                    done_reg;
    logic [1:0]              status_reg;
    logic [7:0]              otask_reg;
    logic [31:0]             oruntime_reg;
    logic [5:0]              onice_reg;
    logic [5:0]              ocount_reg;

    logic                    accept;
    logic                    is_full;
    logic                    is_empty;
    logic                    div_load;
    logic                    div_done;
    logic [RUNTIME_W-1:0]    div_quot;

    cell_ctrl_t              ctrl;
    entry_t                  cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]  cell_gt;
    logic [QUEUE_DEPTH-1:0]  occ;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);
    assign div_load = accept && (action == ACT_ENQ) && !is_full;

    // run_time * 1024 by shift; weight looked up straight from the nice table
    fsrq_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend ({run_time, {SCALE_SHIFT{1'b0}}}),
        .divisor  (weight_of(nice_index)),
        .done     (div_done),
        .quotient (div_quot)
    );

    // cell i is live while i is below the count
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            occ[i] = (CNT_W'(i) < count_reg);
    end

    always_comb
    begin
        ctrl.insert    = (state_reg == S_INS);
        ctrl.shift_out = accept && (action == ACT_DEQ) && !is_empty;
        ctrl.key       = key_reg;
        ctrl.new_entry = '{runtime: key_reg, task_id: task_reg, nice: nice_reg};
    end

    // chain: insert shifts the tail right from the insert point, dequeue
    // shifts everything left by one
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        entry_t prev_e, next_e;
        logic   gt_p;
        if (g == 0)
        begin : g_head
            assign prev_e = cell_entry[g];
            assign gt_p   = 1'b0;
        end
        else
        begin : g_body
            assign prev_e = cell_entry[g-1];
            assign gt_p   = cell_gt[g-1];
        end
        if (g == QUEUE_DEPTH - 1)
        begin : g_tail
            assign next_e = cell_entry[g];
        end
        else
        begin : g_inner
            assign next_e = cell_entry[g+1];
        end

        fsrq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (occ[g]),
            .gt_prev    (gt_p),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .gt         (cell_gt[g]),
            .entry      (cell_entry[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (div_load)
                    state_next = S_DIV;
                if (ctrl.shift_out)
                    count_next = count_reg - 1'b1;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_INS;
            end
            S_INS:
            begin
                state_next = S_IDLE;
                count_next = count_reg + 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (accept && !div_load) || (state_reg == S_INS);
        end
    end

    // command capture, key sum (wraps at 32 bits) and result registers
    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            base_reg <= virtual_runtime;
            task_reg <= task_id[TASK_ID_BITS-1:0];
            nice_reg <= nice_index;
        end
        if (state_reg == S_DIV && div_done)
            key_reg <= base_reg + div_quot;

        if (state_reg == S_INS)
        begin
            status_reg   <= ST_DONE;
            otask_reg    <= '0;
            oruntime_reg <= key_reg;
            onice_reg    <= '0;
            ocount_reg   <= 6'(count_next);
        end
        else if (accept && !div_load)
        begin
            // dequeue, or a rejected transaction
            ocount_reg <= 6'(count_next);
            if (action == ACT_ENQ)
            begin
                status_reg   <= ST_FULL;
                otask_reg    <= '0;
                oruntime_reg <= '0;
                onice_reg    <= '0;
            end
            else if (is_empty)
            begin
                status_reg   <= ST_EMPTY;
                otask_reg    <= '0;
                oruntime_reg <= '0;
                onice_reg    <= '0;
            end
            else
            begin
                status_reg   <= ST_DONE;
                otask_reg    <= 8'(cell_entry[0].task_id);
                oruntime_reg <= cell_entry[0].runtime;
                onice_reg    <= cell_entry[0].nice;
            end
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign out_task_id    = otask_reg;
    assign out_runtime    = oruntime_reg;
    assign out_nice_index = onice_reg;
    assign entry_count    = ocount_reg;

endmodule

// File: hw/rtl/fsrq_checker.sv
module fsrq_checker
    import fsrq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        action,
    input logic        done,
    input logic [1:0]  status,
    input logic [7:0]  out_task_id,
    input logic [31:0] out_runtime,
    input logic [5:0]  out_nice_index,
    input logic [5:0]  entry_count
);

    // every transaction taken either starts work or answers next cycle
    a_take_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("transaction taken without progress");

    // a dequeue never raises busy and answers at once
    a_deq_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_DEQ) |=> (done && !busy))
        else $error("dequeue result late");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (entry_count == 6'd0 && out_runtime == 32'd0))
        else $error("empty status with entries");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (entry_count == 6'(QUEUE_DEPTH) && out_task_id == 8'd0))
        else $error("full status with bad count");

    // an enqueue result never carries task or nice fields
    a_enq_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(busy)) |-> (out_task_id == 8'd0 && out_nice_index == 6'd0))
        else $error("enqueue result carries dequeue fields");

endmodule

bind fair_share_run_queue_core fsrq_checker u_fsrq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .done           (done),
    .status         (status),
    .out_task_id    (out_task_id),
    .out_runtime    (out_runtime),
    .out_nice_index (out_nice_index),
    .entry_count    (entry_count)
);
